### hdl/speaker_tune_sequencer_unit_defines.svh
// assertion macros shared by the rtl files
`ifndef SPEAKER_TUNE_SEQUENCER_UNIT_DEFINES_SVH
`define SPEAKER_TUNE_SEQUENCER_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define STS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define STS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sts_pkg.sv
`default_nettype none

package sts_pkg;

	localparam int TOKEN_BITS = 16;
	localparam int DIV_W      = 32;
	localparam int DIV_STEPS  = DIV_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [DIV_W-1:0]      PIT_CLOCK_HZ  = 32'h0012_34DD;
	localparam logic [TOKEN_BITS-1:0] PITCH_MIN     = 16'd20;
	localparam logic [TOKEN_BITS-1:0] PITCH_MAX     = 16'd20000;
	localparam logic [TOKEN_BITS-1:0] MS_PER_MINUTE = 16'd60000;
	localparam logic [DIV_W-1:0]      WAIT_SAT      = 32'hFFFF_FFFF;

	typedef struct packed {
		logic take_tempo;
		logic take_pitch;
		logic take_dur;
		logic clear_tune;
		logic div_start;
		logic div_sel_wait;
		logic cap_tdiv;
		logic load_note;
		logic load_eot;
	} sts_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_free;
	} sts_status_t;

endpackage

`default_nettype wire

### hdl/speaker_tune_sequencer_unit.sv
// speaker tune sequencer
// input stream: one tune token per beat; s_axis_tuser = 1 marks end of tune,
// otherwise s_axis_tdata is tempo (first token), then pitch / duration pairs
// output stream: one note per duration token and one final silence per end
// of tune; m_axis_tlast marks that final silence
// tempo and pitch tokens are stored while the input stays ready and produce no beat
// a duration token's note is loaded into the output register after a 16x16
// multiply at acceptance, then two 32-step divisions one after the other on
// a single shared restoring divider (timer divisor, then wait time); the
// input is not ready again until the note is loaded
// an end-of-tune token is loaded into the output register from the EOT
// state and returns the sequencer to expect a tempo
// results sit in an output register; while the receiver stalls, tempo
// and pitch tokens are still taken, and a note waits in the controller,
// holding off the input, until the register frees
// reset clears the sequence state, the stored tempo and pitch and the
// output valid; the first token after reset is a tempo
`default_nettype none

module speaker_tune_sequencer_unit
	import sts_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // token_value
	input  wire logic        s_axis_tuser,   // cmd
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // timer_divisor, wait_ms
	output logic             m_axis_tuser,   // speaker_on
	output logic             m_axis_tlast
);

	sts_cmd_t              cmd;
	sts_status_t           status;
	logic [TOKEN_BITS-1:0] timer_divisor;
	logic [DIV_W-1:0]      wait_ms;

	sts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_end   (s_axis_tuser),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.status   (status)
	);

	sts_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.token             (s_axis_tdata[TOKEN_BITS-1:0]),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.out_speaker_on    (m_axis_tuser),
		.out_timer_divisor (timer_divisor),
		.out_wait_ms       (wait_ms),
		.out_last          (m_axis_tlast)
	);

	assign m_axis_tdata = {wait_ms, timer_divisor};

endmodule

`default_nettype wire

### hdl/sts_div.sv
`default_nettype none
`include "speaker_tune_sequencer_unit_defines.svh"

module sts_div
	import sts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIV_W-1:0]      dividend,
	input  wire logic [TOKEN_BITS-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [DIV_W-1:0]           quotient
);

	logic                  busy_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [TOKEN_BITS-1:0] rem_q;
	logic [DIV_W-1:0]      quo_q;
	logic [TOKEN_BITS-1:0] dsr_q;
	logic [TOKEN_BITS:0]   trial;
	logic [TOKEN_BITS:0]   diff;
	logic                  fits;

	// one restoring step per cycle while busy
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TOKEN_BITS-1:0] : trial[TOKEN_BITS-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	`STS_ASSERT_IMP(a_no_restart, clk, arst_n, start, !busy_q, "divider restarted while busy")

endmodule

`default_nettype wire

### hdl/sts_datapath.sv
`default_nettype none

module sts_datapath
	import sts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sts_cmd_t              cmd,
	output sts_status_t                status,
	input  wire logic [TOKEN_BITS-1:0] token,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       out_speaker_on,
	output logic [TOKEN_BITS-1:0]      out_timer_divisor,
	output logic [DIV_W-1:0]           out_wait_ms,
	output logic                       out_last
);

	logic [TOKEN_BITS-1:0] tempo_q;
	logic [TOKEN_BITS-1:0] pitch_q;
	logic [DIV_W-1:0]      prod_q;
	logic [TOKEN_BITS-1:0] tdiv_q;
	logic                  out_valid_q;
	logic                  speaker_on_q;
	logic [TOKEN_BITS-1:0] timer_divisor_q;
	logic [DIV_W-1:0]      wait_ms_q;
	logic                  last_q;
	logic [TOKEN_BITS-1:0] pitch_cl;
	logic [DIV_W-1:0]      div_dividend;
	logic [TOKEN_BITS-1:0] div_divisor;
	logic [DIV_W-1:0]      quotient;
	logic                  div_busy;
	logic                  div_done;
	logic                  tone;

	always_comb begin
		priority if (pitch_q < PITCH_MIN) begin
			pitch_cl = PITCH_MIN;
		end else if (pitch_q > PITCH_MAX) begin
			pitch_cl = PITCH_MAX;
		end else begin
			pitch_cl = pitch_q;
		end
	end

	assign div_dividend = cmd.div_sel_wait ? prod_q : PIT_CLOCK_HZ;
	assign div_divisor  = cmd.div_sel_wait ? tempo_q : pitch_cl;
	assign tone         = pitch_q != '0;

	sts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q <= '0;
			pitch_q <= '0;
		end else if (cmd.clear_tune) begin
			tempo_q <= '0;
			pitch_q <= '0;
		end else begin
			if (cmd.take_tempo) begin
				tempo_q <= token;
			end
			if (cmd.take_pitch) begin
				pitch_q <= token;
			end else if (cmd.load_note) begin
				pitch_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_dur) begin
			prod_q <= DIV_W'(MS_PER_MINUTE) * DIV_W'(token);
		end
		if (cmd.cap_tdiv) begin
			tdiv_q <= quotient[TOKEN_BITS-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_note || cmd.load_eot) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_note) begin
			speaker_on_q    <= tone;
			timer_divisor_q <= tone ? tdiv_q : '0;
			wait_ms_q       <= (tempo_q == '0) ? WAIT_SAT : quotient;
			last_q          <= 1'b0;
		end else if (cmd.load_eot) begin
			speaker_on_q    <= 1'b0;
			timer_divisor_q <= '0;
			wait_ms_q       <= '0;
			last_q          <= 1'b1;
		end
	end

	assign status.div_busy = div_busy;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid         = out_valid_q;
	assign out_speaker_on    = speaker_on_q;
	assign out_timer_divisor = timer_divisor_q;
	assign out_wait_ms       = wait_ms_q;
	assign out_last          = last_q;

endmodule

`default_nettype wire

### hdl/sts_ctrl.sv
`default_nettype none
`include "speaker_tune_sequencer_unit_defines.svh"

module sts_ctrl
	import sts_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic         in_end,
	output logic              in_ready,
	output sts_cmd_t          cmd,
	input  wire sts_status_t  status
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_START1 = 3'd1;
	localparam logic [2:0] ST_WAIT1  = 3'd2;
	localparam logic [2:0] ST_START2 = 3'd3;
	localparam logic [2:0] ST_WAIT2  = 3'd4;
	localparam logic [2:0] ST_LOAD   = 3'd5;
	localparam logic [2:0] ST_EOT    = 3'd6;

	localparam logic [1:0] PH_TEMPO = 2'd0;
	localparam logic [1:0] PH_PITCH = 2'd1;
	localparam logic [1:0] PH_DUR   = 2'd2;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] phase_q;
	logic [1:0] phase_d;
	logic       accept;

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_end) begin
						cmd.clear_tune = 1'b1;
						phase_d        = PH_TEMPO;
						state_d        = ST_EOT;
					end else if (phase_q == PH_PITCH) begin
						cmd.take_pitch = 1'b1;
						phase_d        = PH_DUR;
					end else if (phase_q == PH_DUR) begin
						cmd.take_dur = 1'b1;
						phase_d      = PH_PITCH;
						state_d      = ST_START1;
					end else begin
						cmd.take_tempo = 1'b1;
						phase_d        = PH_PITCH;
					end
				end
			end
			ST_START1: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT1;
			end
			ST_WAIT1: begin
				if (status.div_done) begin
					state_d = ST_START2;
				end
			end
			ST_START2: begin
				cmd.cap_tdiv     = 1'b1;
				cmd.div_start    = 1'b1;
				cmd.div_sel_wait = 1'b1;
				state_d          = ST_WAIT2;
			end
			ST_WAIT2: begin
				cmd.div_sel_wait = 1'b1;
				if (status.div_done) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.div_sel_wait = 1'b1;
				if (status.out_free) begin
					cmd.load_note = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_EOT: begin
				if (status.out_free) begin
					cmd.load_eot = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_TEMPO;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	`STS_ASSERT_IMP(a_load_free, clk, arst_n, cmd.load_note || cmd.load_eot, status.out_free, "result loaded over a pending beat")
	`STS_ASSERT_IMP(a_wait_busy, clk, arst_n, state_q == ST_WAIT1 || state_q == ST_WAIT2, status.div_busy, "waiting on an idle divider")
	`STS_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, !status.div_busy, "input ready while dividing")

endmodule

`default_nettype wire
